// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertion wrappers for the balancer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define IBB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define IBB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ibb_pkg.sv
// ----------------------------------------------------------------------------
// ibb_pkg
// types, constants and microcode for the interrupt bandwidth balancer
// ----------------------------------------------------------------------------
package ibb_pkg;

    localparam int FRAME_SLOTS_DEF = 32;
    localparam int LOAD_WIDTH_DEF  = 32;

    localparam int PER_W   = 6;
    localparam int SLOT_W  = 5;
    localparam int COST_W  = 7;
    localparam int MP_W    = 11;
    localparam int IVL_W   = 8;
    localparam int SPD_SH  = 3;
    localparam int AMT_W   = COST_W + SPD_SH;
    localparam int CNT_W   = 7;
    localparam int LOG_W   = 3;

    localparam logic [MP_W:0]     COST_BASE = 12'd13;
    localparam logic [MP_W:0]     COST_CAP  = 12'd77;

    typedef enum logic
    {
        CMD_OPEN  = 1'b0,
        CMD_CLOSE = 1'b1
    } cmd_t;

    typedef struct packed
    {
        logic                cmd;
        logic [IVL_W-1:0]    interval;
        logic [MP_W-1:0]     max_packet;
        logic                low_speed;
        logic [SLOT_W-1:0]   slot_index;
        logic [PER_W-1:0]    period;
        logic [COST_W-1:0]   scheduled_size;
    } req_t;

    typedef struct packed
    {
        logic [PER_W-1:0]    list_index;
        logic [SLOT_W-1:0]   chosen_slot;
        logic [PER_W-1:0]    chosen_period;
        logic [PER_W-1:0]    repeat_count;
        logic [COST_W-1:0]   cost_recorded;
    } rsp_t;

    // sequencer step addresses
    typedef enum logic [2:0]
    {
        S_WAIT       = 3'd0,
        S_SETUP      = 3'd1,
        S_SUM_ACC    = 3'd2,
        S_SUM_CMP    = 3'd3,
        S_APPLY_INIT = 3'd4,
        S_APPLY_WR   = 3'd5,
        S_RESULT     = 3'd6
    } step_t;

    typedef enum logic [2:0]
    {
        OP_NONE       = 3'd0,
        OP_LOAD       = 3'd1,
        OP_SETUP      = 3'd2,
        OP_ACCUM      = 3'd3,
        OP_COMPARE    = 3'd4,
        OP_APPLY_INIT = 3'd5,
        OP_WRITE      = 3'd6,
        OP_RESULT     = 3'd7
    } op_t;

    typedef enum logic [2:0]
    {
        COND_NEVER     = 3'd0,
        COND_ALWAYS    = 3'd1,
        COND_IN        = 3'd2,
        COND_CLOSE     = 3'd3,
        COND_MORE_IDX  = 3'd4,
        COND_MORE_SLOT = 3'd5,
        COND_OUT_FREE  = 3'd6
    } cond_t;

    // one control word: operation, jump condition, jump target, hold when not taken
    typedef struct packed
    {
        op_t    op;
        cond_t  cond;
        step_t  target;
        logic   hold;
    } ctrl_t;

    function automatic ctrl_t ucode(input step_t step);
        ctrl_t w;
        case (step)
            S_WAIT:       w = '{op: OP_LOAD,       cond: COND_IN,
                                target: S_SETUP,    hold: 1'b1};
            S_SETUP:      w = '{op: OP_SETUP,      cond: COND_CLOSE,
                                target: S_APPLY_WR, hold: 1'b0};
            S_SUM_ACC:    w = '{op: OP_ACCUM,      cond: COND_MORE_IDX,
                                target: S_SUM_ACC,  hold: 1'b0};
            S_SUM_CMP:    w = '{op: OP_COMPARE,    cond: COND_MORE_SLOT,
                                target: S_SUM_ACC,  hold: 1'b0};
            S_APPLY_INIT: w = '{op: OP_APPLY_INIT, cond: COND_NEVER,
                                target: S_WAIT,     hold: 1'b0};
            S_APPLY_WR:   w = '{op: OP_WRITE,      cond: COND_MORE_IDX,
                                target: S_APPLY_WR, hold: 1'b0};
            S_RESULT:     w = '{op: OP_RESULT,     cond: COND_OUT_FREE,
                                target: S_WAIT,     hold: 1'b1};
            default:      w = '{op: OP_NONE,       cond: COND_ALWAYS,
                                target: S_WAIT,     hold: 1'b0};
        endcase
        return w;
    endfunction

    // largest power of two not above the value, between 1 and 32
    function automatic logic [PER_W-1:0] map_period(input logic [IVL_W-1:0] v);
        logic [PER_W-1:0] p;
        if (v >= 8'd32)
            p = 6'd32;
        else if (v >= 8'd16)
            p = 6'd16;
        else if (v >= 8'd8)
            p = 6'd8;
        else if (v >= 8'd4)
            p = 6'd4;
        else if (v >= 8'd2)
            p = 6'd2;
        else
            p = 6'd1;
        return p;
    endfunction

    function automatic logic [LOG_W-1:0] period_log2(input logic [PER_W-1:0] p);
        logic [LOG_W-1:0] l;
        case (p)
            6'd2:    l = 3'd1;
            6'd4:    l = 3'd2;
            6'd8:    l = 3'd3;
            6'd16:   l = 3'd4;
            6'd32:   l = 3'd5;
            default: l = 3'd0;
        endcase
        return l;
    endfunction

    // packet size plus overhead, capped
    function automatic logic [COST_W-1:0] open_cost(input logic [MP_W-1:0] mp);
        logic [MP_W:0] sum;
        sum = {1'b0, mp} + COST_BASE;
        return (sum > COST_CAP) ? COST_CAP[COST_W-1:0] : sum[COST_W-1:0];
    endfunction

endpackage

// File: sv/ibb_req_if.sv
// ----------------------------------------------------------------------------
// ibb_req_if
// request channel: open and close commands with valid/ready handshake
// ----------------------------------------------------------------------------
interface ibb_req_if;
    logic           valid;
    logic           ready;
    ibb_pkg::req_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/ibb_rsp_if.sv
// ----------------------------------------------------------------------------
// ibb_rsp_if
// response channel: chosen list, slot, period and cost with valid/ready
// ----------------------------------------------------------------------------
interface ibb_rsp_if;
    logic           valid;
    logic           ready;
    ibb_pkg::rsp_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/ibb_ram.sv
// ----------------------------------------------------------------------------
// ibb_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ibb_ram #(
    parameter int WIDTH = ibb_pkg::LOAD_WIDTH_DEF,
    parameter int DEPTH = ibb_pkg::FRAME_SLOTS_DEF
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/interrupt_bandwidth_balancer.sv
// ----------------------------------------------------------------------------
// interrupt_bandwidth_balancer
// per-frame interrupt load table with least-loaded phase selection
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  req       in    valid/ready    cmd, interval, max_packet, low_speed,
//                                 slot_index, period, scheduled_size
//  rsp       out   valid/ready    list_index, chosen_slot, chosen_period,
//                                 repeat_count, cost_recorded
//
//  open: setup, a sum and compare over every phase, the write pass, the result;
//  close: setup, the write pass, the result; the single load ram read port visits one
//  entry per cycle. one transaction in flight at a time.
//  reset clears per-entry valid bits at once, no clearing pass.
//  the result sits in an output register; a new request is taken while it
//  waits, and the sequencer holds at its result step only if it is still full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module interrupt_bandwidth_balancer #(
    parameter int FRAME_SLOTS = ibb_pkg::FRAME_SLOTS_DEF,
    parameter int LOAD_WIDTH  = ibb_pkg::LOAD_WIDTH_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    ibb_req_if.sink    req,
    ibb_rsp_if.source  rsp
);

    localparam int PER_W   = ibb_pkg::PER_W;
    localparam int SLOT_W  = ibb_pkg::SLOT_W;
    localparam int COST_W  = ibb_pkg::COST_W;
    localparam int AMT_W   = ibb_pkg::AMT_W;
    localparam int CNT_W   = ibb_pkg::CNT_W;
    localparam int SPD_SH  = ibb_pkg::SPD_SH;
    localparam int IDX_W   = $clog2(FRAME_SLOTS);
    localparam int SUM_W   = LOAD_WIDTH + IDX_W;
    localparam int MAX_PER = 1 << ($clog2(FRAME_SLOTS + 1) - 1);

    localparam logic [CNT_W-1:0] FS_CNT    = CNT_W'(FRAME_SLOTS);
    localparam logic [PER_W-1:0] PER_LIMIT = PER_W'(MAX_PER);

    ibb_pkg::step_t            pc_reg, pc_next;
    ibb_pkg::ctrl_t            cw;
    logic                      jump;

    ibb_pkg::req_t             req_reg, req_next;
    logic [PER_W-1:0]          per_reg, per_next;
    logic [SLOT_W-1:0]         slot_reg, slot_next;
    logic [SLOT_W-1:0]         s_reg, s_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic [SUM_W-1:0]          best_reg, best_next;
    logic [AMT_W-1:0]          amount_reg, amount_next;
    logic [COST_W-1:0]         cost_reg, cost_next;
    logic [FRAME_SLOTS-1:0]    valid_reg, valid_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    ibb_pkg::rsp_t             rsp_data_reg, rsp_data_next;

    logic                      is_close;
    logic [PER_W-1:0]          per_raw, per_calc, per_m1, per_dec;
    logic [SLOT_W-1:0]         slot_wrap;
    logic [COST_W-1:0]         cost_calc;
    logic [AMT_W-1:0]          amount_calc;
    logic [CNT_W-1:0]          idx_ext, idx_adv, s_inc_ext, slot_ext, wrap_ext, raddr_ext;
    logic [CNT_W-1:0]          reps_cnt;
    logic [PER_W-1:0]          s_inc;
    logic                      more_idx, more_slot, out_free, rsp_load;
    logic [LOAD_WIDTH-1:0]     ram_rdata, entry, amt_ext, sat_add, sat_sub, ram_wdata;
    logic [LOAD_WIDTH:0]       add_full;
    logic [SUM_W-1:0]          entry_ext;
    logic [IDX_W-1:0]          ram_raddr;
    logic                      ram_we;

    ibb_ram #(
        .WIDTH (LOAD_WIDTH),
        .DEPTH (FRAME_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // decode of the captured request
    always_comb
    begin
        is_close    = (req_reg.cmd == ibb_pkg::CMD_CLOSE);
        per_raw     = is_close ? ibb_pkg::map_period({2'b00, req_reg.period})
                               : ibb_pkg::map_period(req_reg.interval);
        per_calc    = ({1'b0, per_raw} > FS_CNT) ? PER_LIMIT : per_raw;
        per_m1      = per_calc - PER_W'(1);
        slot_wrap   = req_reg.slot_index & per_m1[SLOT_W-1:0];
        cost_calc   = is_close ? req_reg.scheduled_size
                               : ibb_pkg::open_cost(req_reg.max_packet);
        amount_calc = req_reg.low_speed ? {cost_calc, {SPD_SH{1'b0}}}
                                        : {{SPD_SH{1'b0}}, cost_calc};
    end

    // datapath helpers
    always_comb
    begin
        idx_ext   = {{(CNT_W-IDX_W){1'b0}}, idx_reg};
        idx_adv   = idx_ext + {1'b0, per_reg};
        more_idx  = (idx_adv < FS_CNT);
        s_inc     = {1'b0, s_reg} + PER_W'(1);
        more_slot = (s_inc < per_reg);
        s_inc_ext = {1'b0, s_inc};
        slot_ext  = {2'b00, slot_reg};
        wrap_ext  = {2'b00, slot_wrap};
        reps_cnt  = FS_CNT >> ibb_pkg::period_log2(per_reg);
        per_dec   = per_reg - PER_W'(1);
        out_free  = !rsp_valid_reg || rsp.ready;

        // entries never written read as zero
        entry     = valid_reg[idx_reg] ? ram_rdata : '0;
        entry_ext = {{IDX_W{1'b0}}, entry};
        amt_ext   = {{(LOAD_WIDTH-AMT_W){1'b0}}, amount_reg};
        add_full  = {1'b0, entry} + {1'b0, amt_ext};
        sat_add   = add_full[LOAD_WIDTH] ? '1 : add_full[LOAD_WIDTH-1:0];
        sat_sub   = (entry < amt_ext) ? '0 : (entry - amt_ext);
        ram_wdata = is_close ? sat_sub : sat_add;
    end

    // sequencer: next step and datapath controls from the control word
    always_comb
    begin
        cw = ibb_pkg::ucode(pc_reg);

        case (cw.cond)
            ibb_pkg::COND_NEVER:     jump = 1'b0;
            ibb_pkg::COND_ALWAYS:    jump = 1'b1;
            ibb_pkg::COND_IN:        jump = req.valid;
            ibb_pkg::COND_CLOSE:     jump = is_close;
            ibb_pkg::COND_MORE_IDX:  jump = more_idx;
            ibb_pkg::COND_MORE_SLOT: jump = more_slot;
            ibb_pkg::COND_OUT_FREE:  jump = out_free;
            default:                 jump = 1'b0;
        endcase

        if (jump)
            pc_next = cw.target;
        else if (cw.hold)
            pc_next = pc_reg;
        else
            pc_next = ibb_pkg::step_t'(pc_reg + 3'd1);

        req_next    = req_reg;
        per_next    = per_reg;
        slot_next   = slot_reg;
        s_next      = s_reg;
        idx_next    = idx_reg;
        sum_next    = sum_reg;
        best_next   = best_reg;
        amount_next = amount_reg;
        cost_next   = cost_reg;
        valid_next  = valid_reg;
        raddr_ext   = idx_ext;
        ram_we      = 1'b0;
        rsp_load    = 1'b0;

        case (cw.op)
            ibb_pkg::OP_LOAD:
            begin
                if (req.valid)
                begin
                    req_next = req.data;
                end
            end
            ibb_pkg::OP_SETUP:
            begin
                per_next    = per_calc;
                cost_next   = cost_calc;
                amount_next = amount_calc;
                sum_next    = '0;
                s_next      = '0;
                if (is_close)
                begin
                    slot_next = slot_wrap;
                    idx_next  = wrap_ext[IDX_W-1:0];
                    raddr_ext = wrap_ext;
                end
                else
                begin
                    slot_next = '0;
                    idx_next  = '0;
                    raddr_ext = '0;
                end
            end
            ibb_pkg::OP_ACCUM:
            begin
                sum_next = sum_reg + entry_ext;
                // prefetch the next entry of this phase
                if (more_idx)
                begin
                    idx_next  = idx_adv[IDX_W-1:0];
                    raddr_ext = idx_adv;
                end
            end
            ibb_pkg::OP_COMPARE:
            begin
                // first phase always wins, later ones only when strictly less
                if ((s_reg == '0) || (sum_reg < best_reg))
                begin
                    best_next = sum_reg;
                    slot_next = s_reg;
                end
                s_next   = s_inc[SLOT_W-1:0];
                sum_next = '0;
                if (more_slot)
                begin
                    idx_next  = s_inc_ext[IDX_W-1:0];
                    raddr_ext = s_inc_ext;
                end
            end
            ibb_pkg::OP_APPLY_INIT:
            begin
                idx_next  = slot_ext[IDX_W-1:0];
                raddr_ext = slot_ext;
            end
            ibb_pkg::OP_WRITE:
            begin
                ram_we              = 1'b1;
                valid_next[idx_reg] = 1'b1;
                if (more_idx)
                begin
                    idx_next  = idx_adv[IDX_W-1:0];
                    raddr_ext = idx_adv;
                end
            end
            ibb_pkg::OP_RESULT:
            begin
                rsp_load = out_free;
            end
            default:
            begin
                rsp_load = 1'b0;
            end
        endcase

        ram_raddr = raddr_ext[IDX_W-1:0];

        rsp_data_next = rsp_data_reg;
        if (rsp_load)
        begin
            rsp_data_next.list_index    = is_close ? '0 : (per_dec + {1'b0, slot_reg});
            rsp_data_next.chosen_slot   = is_close ? '0 : slot_reg;
            rsp_data_next.chosen_period = per_reg;
            rsp_data_next.repeat_count  = reps_cnt[PER_W-1:0];
            rsp_data_next.cost_recorded = cost_reg;
        end

        if (rsp_load)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= ibb_pkg::S_WAIT;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            valid_reg     <= valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        per_reg      <= per_next;
        slot_reg     <= slot_next;
        s_reg        <= s_next;
        idx_reg      <= idx_next;
        sum_reg      <= sum_next;
        best_reg     <= best_next;
        amount_reg   <= amount_next;
        cost_reg     <= cost_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign req.ready = (pc_reg == ibb_pkg::S_WAIT);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    `IBB_ASSERT_NEXT(a_accept_to_setup, req.valid && req.ready, pc_reg == ibb_pkg::S_SETUP, "accepted transaction did not start setup")
    `IBB_ASSERT_SAME(a_write_in_range, ram_we, idx_ext < FS_CNT, "load write outside the frame table")
    `IBB_ASSERT_NEXT(a_slot_below_period, rsp_load, rsp.data.chosen_slot < rsp.data.chosen_period, "chosen slot not below its period")

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for interrupt_bandwidth_balancer: a scoreboard class
// keeps its own frame load table, predicts every result from the accepted
// open and close transactions and checks the returned fields in order
// ----------------------------------------------------------------------------
module tb;

    localparam int        SLOTS      = ibb_pkg::FRAME_SLOTS_DEF;
    localparam int        LOAD_W     = ibb_pkg::LOAD_WIDTH_DEF;
    localparam int        PER_W      = ibb_pkg::PER_W;
    localparam int        SLOT_W     = ibb_pkg::SLOT_W;
    localparam int        COST_W     = ibb_pkg::COST_W;
    localparam int        IVL_W      = ibb_pkg::IVL_W;
    localparam int        MP_W       = ibb_pkg::MP_W;
    localparam int        N_RANDOM   = 1450;
    localparam int        CALM_TAIL  = 150;
    localparam int        WDOG_LIMIT = 4000;
    localparam int        DRAIN_WAIT = 100;
    localparam int        OVERHEAD   = 13;
    localparam int        CAP        = 77;
    localparam int        LS_FACTOR  = 8;

    typedef struct
    {
        int   slot;
        int   per;
        int   cost;
        logic low;
    } endpoint_t;

    class load_scoreboard;
        longint unsigned load_tbl[SLOTS];
        ibb_pkg::rsp_t   expected_q[$];
        endpoint_t       live_endpoints[$];
        int              errors;
        int              n_open;
        int              n_close;
        int              n_checked;
        int              n_floor;

        function new();
            foreach (load_tbl[i])
                load_tbl[i] = 0;
            errors    = 0;
            n_open    = 0;
            n_close   = 0;
            n_checked = 0;
            n_floor   = 0;
        endfunction

        // largest power of two not above v, at least 1, at most 32
        function int stride_for(int v);
            int p;
            p = 1;
            while (p < 32 && p * 2 <= v && p * 2 <= SLOTS)
                p = p * 2;
            return p;
        endfunction

        function void spread_load(int slot, int per, longint unsigned amount, bit add);
            longint unsigned top;
            int              idx;
            top = (64'd1 << LOAD_W) - 1;
            for (idx = slot; idx < SLOTS; idx += per)
            begin
                if (add)
                    load_tbl[idx] = (top - load_tbl[idx] < amount) ? top
                                                                   : load_tbl[idx] + amount;
                else if (load_tbl[idx] < amount)
                begin
                    load_tbl[idx] = 0;
                    n_floor++;
                end
                else
                    load_tbl[idx] = load_tbl[idx] - amount;
            end
        endfunction

        function void note_request(ibb_pkg::req_t r);
            ibb_pkg::rsp_t   predicted;
            int              per;
            int              slot;
            int              s;
            int              idx;
            int              cost;
            longint unsigned sum;
            longint unsigned best;
            endpoint_t       ep;
            predicted = '0;
            if (r.cmd == ibb_pkg::CMD_OPEN)
            begin
                per  = stride_for(int'(r.interval));
                slot = 0;
                best = 0;
                for (s = 0; s < per; s++)
                begin
                    sum = 0;
                    for (idx = s; idx < SLOTS; idx += per)
                        sum += load_tbl[idx];
                    // first slot wins a tie
                    if (s == 0 || sum < best)
                    begin
                        best = sum;
                        slot = s;
                    end
                end
                cost = int'(r.max_packet) + OVERHEAD;
                if (cost > CAP)
                    cost = CAP;
                spread_load(slot, per, r.low_speed ? cost * LS_FACTOR : cost, 1'b1);
                predicted.list_index    = PER_W'(per - 1 + slot);
                predicted.chosen_slot   = SLOT_W'(slot);
                predicted.cost_recorded = COST_W'(cost);
                ep.slot = slot;
                ep.per  = per;
                ep.cost = cost;
                ep.low  = r.low_speed;
                live_endpoints.push_back(ep);
                n_open++;
            end
            else
            begin
                per  = stride_for(int'(r.period));
                slot = int'(r.slot_index) & (per - 1);
                spread_load(slot, per,
                            r.low_speed ? int'(r.scheduled_size) * LS_FACTOR
                                        : int'(r.scheduled_size), 1'b0);
                predicted.cost_recorded = r.scheduled_size;
                n_close++;
            end
            predicted.chosen_period = PER_W'(per);
            predicted.repeat_count  = PER_W'(SLOTS / per);
            expected_q.push_back(predicted);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_response(ibb_pkg::rsp_t got);
            ibb_pkg::rsp_t want;
            if (expected_q.size() == 0)
            begin
                $error("result with nothing outstanding: %p", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("list_index", want.list_index, got.list_index);
            compare_field("chosen_slot", want.chosen_slot, got.chosen_slot);
            compare_field("chosen_period", want.chosen_period, got.chosen_period);
            compare_field("repeat_count", want.repeat_count, got.repeat_count);
            compare_field("cost_recorded", want.cost_recorded, got.cost_recorded);
            n_checked++;
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ibb_req_if req_ch();
    ibb_rsp_if rsp_ch();

    interrupt_bandwidth_balancer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    load_scoreboard sb = new();

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side: check accepted transactions, then decide next ready
    always @(posedge clk)
    begin
        if (rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.data);
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (rx_stall_pct != 0 && $urandom_range(1, 100) <= rx_stall_pct)
        begin
            stall_left = $urandom_range(0, 17);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WDOG_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", WDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic ibb_pkg::req_t make_open(int ivl, int mp, logic low);
        ibb_pkg::req_t r;
        r.cmd            = ibb_pkg::CMD_OPEN;
        r.interval       = IVL_W'(ivl);
        r.max_packet     = MP_W'(mp);
        r.low_speed      = low;
        // close-only fields carry junk on an open
        r.slot_index     = SLOT_W'($urandom);
        r.period         = PER_W'($urandom);
        r.scheduled_size = COST_W'($urandom);
        return r;
    endfunction

    function automatic ibb_pkg::req_t make_close(int slot, int per, int sched, logic low);
        ibb_pkg::req_t r;
        r.cmd            = ibb_pkg::CMD_CLOSE;
        r.interval       = IVL_W'($urandom);
        r.max_packet     = MP_W'($urandom);
        r.low_speed      = low;
        r.slot_index     = SLOT_W'(slot);
        r.period         = PER_W'(per);
        r.scheduled_size = COST_W'(sched);
        return r;
    endfunction

    task automatic push_request(input ibb_pkg::req_t r);
        if (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(r);
    endtask

    // close one endpoint that is still open, with the values it was given
    task automatic retire_endpoint();
        int        k;
        endpoint_t ep;
        k  = $urandom_range(0, sb.live_endpoints.size() - 1);
        ep = sb.live_endpoints[k];
        sb.live_endpoints.delete(k);
        push_request(make_close(ep.slot, ep.per, ep.cost, ep.low));
    endtask

    task automatic random_open();
        int ivl;
        int mp;
        ivl = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 40)
                                          : $urandom_range(0, 255);
        mp  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 2047)
                                          : $urandom_range(0, 80);
        push_request(make_open(ivl, mp, $urandom_range(0, 1)));
    endtask

    initial
    begin
        int n;
        int pick;
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: close on an empty table floors at zero
        push_request(make_close(31, 63, 127, 1'b1));
        // opens across every period and the cost cap edges
        push_request(make_open(0, 0, 1'b0));
        push_request(make_open(1, 2047, 1'b1));
        push_request(make_open(2, 64, 1'b0));
        push_request(make_open(3, 65, 1'b1));
        push_request(make_open(4, 100, 1'b0));
        push_request(make_open(7, 1, 1'b0));
        push_request(make_open(8, 30, 1'b1));
        push_request(make_open(15, 63, 1'b0));
        push_request(make_open(16, 5, 1'b0));
        push_request(make_open(31, 77, 1'b0));
        push_request(make_open(32, 2047, 1'b1));
        push_request(make_open(255, 0, 1'b0));
        push_request(make_open(128, 1024, 1'b1));
        // closes with odd periods, wrapped slots and oversized costs
        push_request(make_close(5, 0, 0, 1'b0));
        push_request(make_close(7, 3, 77, 1'b0));
        push_request(make_close(31, 32, 127, 1'b1));
        push_request(make_close(17, 48, 20, 1'b0));
        push_request(make_close(0, 1, 90, 1'b1));
        push_request(make_close(20, 16, 1, 1'b0));
        push_request(make_close(30, 6, 64, 1'b1));
        retire_endpoint();
        retire_endpoint();

        for (n = 0; n < N_RANDOM; n++)
        begin
            if (n >= N_RANDOM - CALM_TAIL)
            begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            else if (n % 100 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        tx_idle_pct  = 0;
                        rx_stall_pct = 0;
                    end
                    1:
                    begin
                        tx_idle_pct  = 30;
                        rx_stall_pct = 0;
                    end
                    2:
                    begin
                        tx_idle_pct  = 0;
                        rx_stall_pct = 8;
                    end
                    default:
                    begin
                        tx_idle_pct  = 60;
                        rx_stall_pct = 15;
                    end
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
                push_request(make_close($urandom_range(0, 31), $urandom_range(0, 63),
                                        $urandom_range(0, 127), $urandom_range(0, 1)));
            else if (sb.live_endpoints.size() != 0 &&
                     (sb.live_endpoints.size() > 24 || pick < 45))
                retire_endpoint();
            else
                random_open();
        end
        req_ch.valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.expected_q.size() != 0)
        begin
            $error("%0d results never arrived", sb.expected_q.size());
            sb.errors++;
        end

        $display("covered %0d opens and %0d closes, %0d results compared",
                 sb.n_open, sb.n_close, sb.n_checked);
        $display("load entries floored at zero on close: %0d", sb.n_floor);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// File: files.f
+incdir+sv
sv/ibb_pkg.sv
sv/ibb_req_if.sv
sv/ibb_rsp_if.sv
sv/ibb_ram.sv
sv/interrupt_bandwidth_balancer.sv
tb/sv/tb.sv
